FILE: rtl/two_class_age_ordered_queue_defines.svh
// Assertion macros shared by the two-class age-ordered queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TWO_CLASS_AGE_ORDERED_QUEUE_DEFINES_SVH
`define TWO_CLASS_AGE_ORDERED_QUEUE_DEFINES_SVH

// The condition must never hold at a clock edge outside reset.
`define TCAOQ_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tcaoq assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define TCAOQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcaoq assertion failed");

`endif

FILE: rtl/tcaoq_pkg.sv
// Package for the two-class age-ordered queue: payload types, codes and
// the command and status structs between controller and datapath. No dependencies.
package tcaoq_pkg;

   localparam int ID_WIDTH            = 16;
   localparam int SEQ_WIDTH           = 6;
   localparam int DEFAULT_QUEUE_DEPTH = 16;

   // Command codes.
   localparam logic [1:0] CMD_PUSH    = 2'd0;
   localparam logic [1:0] CMD_POP     = 2'd1;
   localparam logic [1:0] CMD_POP_ANY = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_PUSHED = 2'd0;
   localparam logic [1:0] STATUS_POPPED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   typedef struct packed {
      logic [1:0]          command;
      logic                animal_class;
      logic [ID_WIDTH-1:0] item_id;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [ID_WIDTH-1:0] popped_id;
      logic                popped_class;
   } rsp_type;

   // One stored entry: identifier above the arrival sequence number.
   typedef struct packed {
      logic [ID_WIDTH-1:0]  id;
      logic [SEQ_WIDTH-1:0] seq;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic rsp_busy;
   } ctrl_stat_type;

   // Datapath to one class queue.
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_cmd_type;

   // One class queue back to the datapath.
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

FILE: rtl/tcaoq_fifo.sv
// One class queue: entry memory, read and write pointers, fill count and a
// registered head read. Depends on tcaoq_pkg and the defines header.
`include "two_class_age_ordered_queue_defines.svh"

module tcaoq_fifo #(
   parameter int QUEUE_DEPTH = tcaoq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tcaoq_pkg::fifo_cmd_type cmd,
   input  tcaoq_pkg::entry_type    push_entry,
   output tcaoq_pkg::entry_type    head_entry,
   output tcaoq_pkg::fifo_stat_type stat
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

   tcaoq_pkg::entry_type entries_ff [QUEUE_DEPTH];
   tcaoq_pkg::entry_type head_ff;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;

   // Pointer advance with wrap at the last entry, and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (cmd.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (cmd.push && !cmd.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry memory: one write port at the tail, one registered read at the head.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
      head_ff <= entries_ff[rd_ptr_ff];
   end

   assign head_entry = head_ff;
   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == FULL_FILL);

   `TCAOQ_ASSERT_NEVER(a_fill_in_range, clock, reset, fill_ff > FULL_FILL)
   `TCAOQ_ASSERT_NEVER(a_no_push_full, clock, reset, cmd.push && stat.full)
   `TCAOQ_ASSERT_NEVER(a_no_pop_empty, clock, reset, cmd.pop && stat.empty)
   `TCAOQ_ASSERT_NEXT(a_push_grows, clock, reset, cmd.push && !cmd.pop,
                      fill_ff == $past(fill_ff) + 1'b1)

endmodule

FILE: rtl/tcaoq_ctrl.sv
// Controller for the two-class age-ordered queue: sequences capture, head
// lookup and execution of one command. Depends on tcaoq_pkg.
module tcaoq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tcaoq_pkg::ctrl_stat_type stat,
   output tcaoq_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_EXEC   = 2'd2;

   logic [1:0] state_ff, state_in;

   // Take a beat in idle, wait in the lookup state for the head reads, then execute
   // as soon as the result register has room.
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!stat.rsp_busy) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/tcaoq_datapath.sv
// Datapath for the two-class age-ordered queue: command register, sequence
// counter, both class queues, age compare and result register.
// Depends on tcaoq_pkg and tcaoq_fifo.
module tcaoq_datapath #(
   parameter int QUEUE_DEPTH = tcaoq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcaoq_pkg::req_type       req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tcaoq_pkg::rsp_type       rsp_payload,
   input  tcaoq_pkg::ctrl_cmd_type  cmd,
   output tcaoq_pkg::ctrl_stat_type stat
);

   localparam int SEQ_W = tcaoq_pkg::SEQ_WIDTH;

   tcaoq_pkg::req_type       req_ff;
   tcaoq_pkg::rsp_type       rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SEQ_W-1:0]         seq_ff, seq_in;
   tcaoq_pkg::fifo_cmd_type  q_cmd [2];
   tcaoq_pkg::fifo_stat_type q_stat [2];
   tcaoq_pkg::entry_type     q_head [2];
   tcaoq_pkg::entry_type     push_entry;
   logic [SEQ_W-1:0]         seq_diff;
   logic                     first_older;
   logic                     pop_sel;
   logic                     do_pop;

   // Command register, loaded when the controller takes a beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   // The first head is older when its wrapped distance to the second
   // head is non-zero and below half the sequence range.
   assign seq_diff    = q_head[1].seq - q_head[0].seq;
   assign first_older = (seq_diff != '0) && !seq_diff[SEQ_W-1];

   assign push_entry.id  = req_ff.item_id;
   assign push_entry.seq = seq_ff;

   // Decode the held command into queue operations and a result.
   always_comb begin
      q_cmd[0]     = '0;
      q_cmd[1]     = '0;
      seq_in       = seq_ff;
      pop_sel      = req_ff.animal_class;
      do_pop       = 1'b0;
      rsp_in       = '0;
      rsp_in.status = tcaoq_pkg::STATUS_EMPTY;
      unique case (req_ff.command)
         tcaoq_pkg::CMD_PUSH: begin
            if (q_stat[req_ff.animal_class].full) begin
               rsp_in.status = tcaoq_pkg::STATUS_FULL;
            end else begin
               rsp_in.status = tcaoq_pkg::STATUS_PUSHED;
               q_cmd[req_ff.animal_class].push = cmd.execute;
               if (cmd.execute) begin
                  seq_in = seq_ff + 1'b1;
               end
            end
         end
         tcaoq_pkg::CMD_POP: begin
            do_pop = !q_stat[req_ff.animal_class].empty;
         end
         tcaoq_pkg::CMD_POP_ANY: begin
            priority if (q_stat[0].empty && q_stat[1].empty) begin
               do_pop = 1'b0;
            end else if (q_stat[1].empty) begin
               pop_sel = 1'b0;
               do_pop  = 1'b1;
            end else if (q_stat[0].empty) begin
               pop_sel = 1'b1;
               do_pop  = 1'b1;
            end else begin
               pop_sel = !first_older;
               do_pop  = 1'b1;
            end
         end
         tcaoq_pkg::CMD_NONE: begin
            do_pop = 1'b0;
         end
         default: begin
            do_pop = 1'b0;
         end
      endcase
      if (do_pop) begin
         rsp_in.status       = tcaoq_pkg::STATUS_POPPED;
         rsp_in.popped_id    = q_head[pop_sel].id;
         rsp_in.popped_class = pop_sel;
         q_cmd[pop_sel].pop  = cmd.execute;
      end
   end

   // Class queues, one per class.
   for (genvar gi = 0; gi < 2; gi++) begin : g_queue
      tcaoq_fifo #(
         .QUEUE_DEPTH (QUEUE_DEPTH)
      ) u_fifo (
         .clock      (clock),
         .reset      (reset),
         .cmd        (q_cmd[gi]),
         .push_entry (push_entry),
         .head_entry (q_head[gi]),
         .stat       (q_stat[gi])
      );
   end

   // Result register: loaded on execute, emptied when the beat is taken.
   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seq_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         seq_ff       <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

endmodule

FILE: rtl/two_class_age_ordered_queue.sv
// Two-class age-ordered queue. A command passes from the accepted beat to its result
// beat through capture, head read from the entry memory and execute, in that order.
// A new command is taken only after the previous one has executed, and execute waits
// while the result register holds a beat that is not yet taken.
// Synchronous active-high reset empties both queues and clears the sequence
// counter; entry memories are not cleared and need no clearing pass.
module two_class_age_ordered_queue #(
   parameter int QUEUE_DEPTH = tcaoq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tcaoq_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcaoq_pkg::rsp_type rsp_payload
);

   tcaoq_pkg::ctrl_cmd_type  ctrl_cmd;
   tcaoq_pkg::ctrl_stat_type ctrl_stat;

   // Sequencing of each command.
   tcaoq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (ctrl_stat),
      .cmd       (ctrl_cmd)
   );

   // Queues, age compare and result register.
   tcaoq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (ctrl_cmd),
      .stat        (ctrl_stat)
   );

endmodule

FILE: tb/tb_two_class_age_ordered_queue.sv
// Self-checking testbench for the two-class age-ordered queue: a clocked driver and
// monitor around the block, with an in-bench predictor of both class queues.
// Depends on tcaoq_pkg and the two_class_age_ordered_queue RTL only.
module tb_two_class_age_ordered_queue;

   localparam int QUEUE_DEPTH    = tcaoq_pkg::DEFAULT_QUEUE_DEPTH;
   localparam int SEQ_HALF       = 1 << (tcaoq_pkg::SEQ_WIDTH - 1);
   localparam int STALL_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int PHASE_ITEMS    = 600;
   localparam logic FIRST_CLASS  = 1'b0;
   localparam logic SECOND_CLASS = 1'b1;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   tcaoq_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   tcaoq_pkg::rsp_type rsp_payload;

   // Commands waiting to be driven, and results the predictor has promised.
   tcaoq_pkg::req_type pending_reqs[$];
   tcaoq_pkg::rsp_type awaited_results[$];
   int      issued_count   = 0;
   int      accepted_count = 0;
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;
   int      send_idle_pct  = 35;
   int      recv_idle_pct  = 78;
   logic    req_beat_done  = 1'b0;

   // Predicted contents of both class queues and the arrival counter.
   tcaoq_pkg::entry_type           shelf[2][QUEUE_DEPTH];
   int                             shelf_head[2];
   int                             shelf_fill[2];
   logic [tcaoq_pkg::SEQ_WIDTH-1:0] arrival_no;

   two_class_age_ordered_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Applies one accepted command to the predicted queues and returns its result.
   task automatic predict_outcome(input tcaoq_pkg::req_type cmd,
                                  output tcaoq_pkg::rsp_type outcome);
      logic                            lane;
      logic                            take;
      logic [tcaoq_pkg::SEQ_WIDTH-1:0] gap;
      tcaoq_pkg::entry_type            slot;
      outcome        = '0;
      outcome.status = tcaoq_pkg::STATUS_EMPTY;
      lane           = cmd.animal_class;
      take           = 1'b0;
      case (cmd.command)
         tcaoq_pkg::CMD_PUSH: begin
            if (shelf_fill[lane] >= QUEUE_DEPTH) begin
               outcome.status = tcaoq_pkg::STATUS_FULL;
            end else begin
               slot.id  = cmd.item_id;
               slot.seq = arrival_no;
               shelf[lane][(shelf_head[lane] + shelf_fill[lane]) % QUEUE_DEPTH] = slot;
               shelf_fill[lane]++;
               arrival_no++;
               outcome.status = tcaoq_pkg::STATUS_PUSHED;
            end
         end
         tcaoq_pkg::CMD_POP: begin
            take = (shelf_fill[lane] != 0);
         end
         tcaoq_pkg::CMD_POP_ANY: begin
            if (shelf_fill[FIRST_CLASS] == 0 && shelf_fill[SECOND_CLASS] == 0) begin
               take = 1'b0;
            end else if (shelf_fill[SECOND_CLASS] == 0) begin
               lane = FIRST_CLASS;
               take = 1'b1;
            end else if (shelf_fill[FIRST_CLASS] == 0) begin
               lane = SECOND_CLASS;
               take = 1'b1;
            end else begin
               // Wrapped distance between heads; ties go to the second class.
               gap  = shelf[SECOND_CLASS][shelf_head[SECOND_CLASS]].seq
                    - shelf[FIRST_CLASS][shelf_head[FIRST_CLASS]].seq;
               lane = (gap != 0 && gap < SEQ_HALF) ? FIRST_CLASS : SECOND_CLASS;
               take = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (take) begin
         slot                 = shelf[lane][shelf_head[lane]];
         shelf_head[lane]     = (shelf_head[lane] + 1) % QUEUE_DEPTH;
         shelf_fill[lane]--;
         outcome.status       = tcaoq_pkg::STATUS_POPPED;
         outcome.popped_id    = slot.id;
         outcome.popped_class = lane;
      end
   endtask

   // Request driver: a beat is held until accepted, gaps are drawn per cycle.
   always @(negedge clock) begin : drive_req
      logic show;
      if (!reset) begin
         show = req_valid && !req_beat_done;
         if (!show && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_reqs[0];
            pending_reqs.delete(0);
            show = 1'b1;
         end
         req_valid <= show;
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predicts on each request beat, checks each result beat, guards progress.
   always @(posedge clock) begin : watch_beats
      tcaoq_pkg::rsp_type want;
      if (reset) begin
         req_beat_done <= 1'b0;
         arrival_no    = '0;
         shelf_head    = '{0, 0};
         shelf_fill    = '{0, 0};
         quiet_cycles  = 0;
      end else begin
         req_beat_done <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_outcome(req_payload, want);
            awaited_results.insert(awaited_results.size(), want);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result beat status %0d id %h class %0d with none awaited",
                                         rsp_payload.status, rsp_payload.popped_id,
                                         rsp_payload.popped_class));
            end else begin
               want = awaited_results[0];
               awaited_results.delete(0);
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_payload.status, want.status));
               if (rsp_payload.popped_id !== want.popped_id)
                  report_mismatch($sformatf("popped_id %h, expected %h",
                                            rsp_payload.popped_id, want.popped_id));
               if (rsp_payload.popped_class !== want.popped_class)
                  report_mismatch($sformatf("popped_class %0d, expected %0d",
                                            rsp_payload.popped_class, want.popped_class));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic queue_cmd(input logic [1:0] cmd, input logic lane,
                            input logic [tcaoq_pkg::ID_WIDTH-1:0] id);
      tcaoq_pkg::req_type r;
      r.command      = cmd;
      r.animal_class = lane;
      r.item_id      = id;
      pending_reqs.insert(pending_reqs.size(), r);
      issued_count++;
   endtask

   // Random traffic in runs: filling, draining, ageing one head, hammering full, mixed.
   task automatic generate_traffic(input int target);
      int   made;
      int   run_len;
      int   i;
      int   pick;
      logic lane;
      made = 0;
      while (made < target) begin
         run_len = $urandom_range(40, 4);
         lane    = 1'($urandom_range(1));
         case ($urandom_range(4))
            0: begin
               for (i = 0; i < run_len; i++) begin
                  pick = $urandom_range(99);
                  if (pick < 80)
                     queue_cmd(tcaoq_pkg::CMD_PUSH, lane, 16'($urandom));
                  else if (pick < 90)
                     queue_cmd(tcaoq_pkg::CMD_POP, lane, 16'($urandom));
                  else
                     queue_cmd(tcaoq_pkg::CMD_POP_ANY, 1'($urandom_range(1)), 16'($urandom));
               end
               made += run_len;
            end
            1: begin
               for (i = 0; i < run_len; i++) begin
                  pick = $urandom_range(99);
                  if (pick < 45)
                     queue_cmd(tcaoq_pkg::CMD_POP_ANY, 1'($urandom_range(1)), 16'($urandom));
                  else if (pick < 80)
                     queue_cmd(tcaoq_pkg::CMD_POP, 1'($urandom_range(1)), 16'($urandom));
                  else
                     queue_cmd(tcaoq_pkg::CMD_PUSH, 1'($urandom_range(1)), 16'($urandom));
               end
               made += run_len;
            end
            2: begin
               // One head waits while the other class churns, so arrival numbers drift apart.
               queue_cmd(tcaoq_pkg::CMD_PUSH, lane, 16'($urandom));
               for (i = 0; i < run_len; i++) begin
                  queue_cmd(tcaoq_pkg::CMD_PUSH, ~lane, 16'($urandom));
                  queue_cmd(tcaoq_pkg::CMD_POP, ~lane, 16'($urandom));
               end
               queue_cmd(tcaoq_pkg::CMD_PUSH, ~lane, 16'($urandom));
               queue_cmd(tcaoq_pkg::CMD_POP_ANY, 1'($urandom_range(1)), 16'($urandom));
               queue_cmd(tcaoq_pkg::CMD_POP_ANY, 1'($urandom_range(1)), 16'($urandom));
               made += 2 * run_len + 4;
            end
            3: begin
               for (i = 0; i < run_len; i++)
                  queue_cmd(2'($urandom_range(2)), 1'($urandom_range(1)), 16'($urandom));
               made += run_len;
            end
            default: begin
               for (i = 0; i < QUEUE_DEPTH + 2; i++)
                  queue_cmd(tcaoq_pkg::CMD_PUSH, lane, 16'($urandom));
               for (i = 0; i < 3; i++) queue_cmd(tcaoq_pkg::CMD_POP, lane, 16'($urandom));
               made += QUEUE_DEPTH + 5;
            end
         endcase
         // Occasional unused command code as noise.
         if ($urandom_range(7) == 0)
            queue_cmd(tcaoq_pkg::CMD_NONE, 1'($urandom_range(1)), 16'($urandom));
      end
   endtask

   task automatic wait_drained;
      while (accepted_count != issued_count || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int i;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pops, unused code, extreme ids, oldest-first order, full queue.
      queue_cmd(tcaoq_pkg::CMD_POP, FIRST_CLASS, 16'hFFFF);
      queue_cmd(tcaoq_pkg::CMD_POP, SECOND_CLASS, 16'h0000);
      queue_cmd(tcaoq_pkg::CMD_POP_ANY, FIRST_CLASS, 16'h0000);
      queue_cmd(tcaoq_pkg::CMD_NONE, SECOND_CLASS, 16'hFFFF);
      queue_cmd(tcaoq_pkg::CMD_PUSH, FIRST_CLASS, 16'h0000);
      queue_cmd(tcaoq_pkg::CMD_PUSH, SECOND_CLASS, 16'hFFFF);
      queue_cmd(tcaoq_pkg::CMD_PUSH, FIRST_CLASS, 16'h5555);
      queue_cmd(tcaoq_pkg::CMD_POP_ANY, SECOND_CLASS, 16'h0000);
      queue_cmd(tcaoq_pkg::CMD_POP_ANY, FIRST_CLASS, 16'h0000);
      queue_cmd(tcaoq_pkg::CMD_POP_ANY, SECOND_CLASS, 16'h0000);
      for (i = 0; i <= QUEUE_DEPTH; i++)
         queue_cmd(tcaoq_pkg::CMD_PUSH, SECOND_CLASS, 16'($urandom));
      queue_cmd(tcaoq_pkg::CMD_POP, SECOND_CLASS, 16'hAAAA);

      // Sender idles lightly, receiver heavily.
      generate_traffic(PHASE_ITEMS);
      wait_drained();
      @(posedge clock);

      // Roles swapped.
      send_idle_pct = 78;
      recv_idle_pct = 35;
      generate_traffic(PHASE_ITEMS);
      wait_drained();
      @(posedge clock);

      // Full rate on both channels.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      generate_traffic(PHASE_ITEMS);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (awaited_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tcaoq_pkg.sv
rtl/tcaoq_fifo.sv
rtl/tcaoq_ctrl.sv
rtl/tcaoq_datapath.sv
rtl/two_class_age_ordered_queue.sv
tb/tb_two_class_age_ordered_queue.sv
